FILE: sv/mpsm_pkg.sv
// package: types, pattern tables and helper functions for the substring matcher
`default_nettype none
package mpsm_pkg;

  localparam int unsigned CHAR_W             = 16;
  localparam int unsigned SYM_W              = 8;
  localparam int unsigned NUM_PAT            = 8;
  localparam int unsigned IDX_W              = 3;
  localparam int unsigned PAT_LEN_MAX        = 59;
  localparam int unsigned NUM_LONG_PATTERNS  = 8;
  localparam int unsigned NUM_SHORT_PATTERNS = 4;

  typedef logic [SYM_W-1:0]                   sym_t;
  typedef logic [PAT_LEN_MAX*SYM_W-1:0]       pat_t;
  typedef logic [(PAT_LEN_MAX-1)*SYM_W-1:0]   win_t;
  typedef logic [NUM_PAT-1:0]                 hits_t;
  typedef logic [IDX_W-1:0]                   idx_t;

  localparam logic PAT_SET_SHORT = 1'b0;
  localparam logic PAT_SET_LONG  = 1'b1;

  localparam sym_t NEVER_SYM  = 8'h80;
  localparam sym_t ASCII_MAX  = 8'h7F;
  localparam sym_t UPPER_A    = 8'h41;
  localparam sym_t UPPER_Z    = 8'h5A;
  localparam sym_t CASE_DELTA = 8'h20;

  // newest character sits in the low byte, zero bytes above the pattern are unused
  localparam pat_t LONG_PAT [NUM_PAT] = '{
    "some installation files are corrupt",
    "error reading setup initialization file",
    "setup cannot extract files necessary to install",
    "the installation program appears to be damaged or corrupted",
    "setup was unable to shutdown system",
    "corrupt cabinet file",
    "the installer you are trying to use is corrupted",
    "hotfix package"
  };

  localparam pat_t SHORT_PAT [NUM_PAT] = '{
    "install",
    "setup",
    "hotfix package",
    "self-extractor",
    '0, '0, '0, '0
  };

  function automatic sym_t fold_char(logic [CHAR_W-1:0] c);
    sym_t s;
    if (c[CHAR_W-1:SYM_W] != '0 || c[SYM_W-1:0] > ASCII_MAX) begin
      s = NEVER_SYM;
    end else if (c[SYM_W-1:0] >= UPPER_A && c[SYM_W-1:0] <= UPPER_Z) begin
      s = c[SYM_W-1:0] + CASE_DELTA;
    end else begin
      s = c[SYM_W-1:0];
    end
    return s;
  endfunction

  // empty pattern never matches
  function automatic logic pat_match(pat_t p, pat_t w);
    logic m;
    m = (p != '0);
    for (int j = 0; j < PAT_LEN_MAX; j++) begin
      if (p[j*SYM_W +: SYM_W] != '0 && p[j*SYM_W +: SYM_W] != w[j*SYM_W +: SYM_W]) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic idx_t lowest_idx(hits_t h);
    idx_t idx;
    idx = '0;
    for (int j = NUM_PAT - 1; j >= 0; j--) begin
      if (h[j]) begin
        idx = idx_t'(j);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mpsm_if.sv
// interfaces: character request channel and result request channel
`default_nettype none
interface mpsm_in_if;
  logic                             valid;
  logic                             ready;
  logic [mpsm_pkg::CHAR_W-1:0]      char_code;
  logic                             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface mpsm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [mpsm_pkg::IDX_W-1:0]       pattern_index;

  modport source (output valid, output found, output pattern_index, input ready);
  modport sink   (input valid, input found, input pattern_index, output ready);
endinterface
`default_nettype wire

FILE: sv/multi_pattern_substring_matcher.sv
// top level: case-insensitive multi-pattern substring matcher
//
//   channel  dir  handshake        payload
//   in_ch    in   valid/ready      char_code[15:0], last_char
//   out_ch   out  valid/ready      found, pattern_index[2:0]
//   cfg_*    in   cfg_wr_en        cfg_wr_data (pattern_set)
//
// one character per cycle while in_ch.ready is high; all pattern compares run in the
// accepting cycle against the window register plus the incoming folded character.
// a result appears in the cycle after the last character is accepted.
// in_ch.ready drops only while a result sits unclaimed in the output register.
// synchronous active-low reset clears window, hit flags, result valid and pattern_set.
`default_nettype none
module multi_pattern_substring_matcher (
  input  logic              clk,
  input  logic              rst_n,
  mpsm_in_if.sink           in_ch,
  mpsm_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  logic                  pattern_set_r;
  mpsm_pkg::win_t        window_r;
  mpsm_pkg::win_t        window_nxt;
  mpsm_pkg::pat_t        cur_win;
  mpsm_pkg::hits_t       hit_flags_r;
  mpsm_pkg::hits_t       hit_flags_nxt;
  mpsm_pkg::hits_t       hits;
  mpsm_pkg::hits_t       hit_all;
  logic                  in_acc;
  logic                  out_valid_r;
  logic                  found_r;
  mpsm_pkg::idx_t        pattern_index_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cur_win = {window_r, mpsm_pkg::fold_char(in_ch.char_code)};

  always_comb begin
    for (int i = 0; i < mpsm_pkg::NUM_PAT; i++) begin
      if (pattern_set_r == mpsm_pkg::PAT_SET_LONG) begin
        hits[i] = (i < mpsm_pkg::NUM_LONG_PATTERNS) &&
                  mpsm_pkg::pat_match(mpsm_pkg::LONG_PAT[i], cur_win);
      end else begin
        hits[i] = (i < mpsm_pkg::NUM_SHORT_PATTERNS) &&
                  mpsm_pkg::pat_match(mpsm_pkg::SHORT_PAT[i], cur_win);
      end
    end
  end

  assign hit_all = hit_flags_r | hits;

  // end of string clears window and flags
  always_comb begin
    window_nxt    = window_r;
    hit_flags_nxt = hit_flags_r;
    if (in_acc) begin
      if (in_ch.last_char) begin
        window_nxt    = '0;
        hit_flags_nxt = '0;
      end else begin
        window_nxt    = cur_win[$bits(mpsm_pkg::win_t)-1:0];
        hit_flags_nxt = hit_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r      <= '0;
      hit_flags_r   <= '0;
      pattern_set_r <= mpsm_pkg::PAT_SET_SHORT;
      out_valid_r   <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      hit_flags_r <= hit_flags_nxt;
      if (cfg_wr_en) begin
        pattern_set_r <= cfg_wr_data;
      end
      if (in_acc && in_ch.last_char) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_char) begin
      found_r         <= |hit_all;
      pattern_index_r <= mpsm_pkg::lowest_idx(hit_all);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.pattern_index = pattern_index_r;

`ifndef SYNTH
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_char) |=> out_valid_r)
    else $error("no result after last character");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_char) |=> (hit_flags_r == '0 && window_r == '0))
    else $error("window or flags not cleared after last character");

  a_no_find_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (pattern_index_r == '0))
    else $error("nonzero index without a find");

  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.last_char) |=> ((hit_flags_r & $past(hit_flags_r)) == $past(hit_flags_r)))
    else $error("hit flag lost mid-string");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// testbench: drives strings into the substring matcher and checks every verdict against a predictor
`default_nettype none
module testbench;

  localparam int WINDOW_DEPTH = 64;

  typedef logic [mpsm_pkg::CHAR_W-1:0] code_t;

  typedef struct packed {
    logic             found;
    mpsm_pkg::idx_t   index;
  } verdict_t;

  typedef enum int unsigned {INTACT, FLIP_BIT, HIGH_BYTE, DROP_CHAR} damage_t;

  class match_scoreboard;
    string long_msgs[mpsm_pkg::NUM_LONG_PATTERNS] = '{
      "some installation files are corrupt",
      "error reading setup initialization file",
      "setup cannot extract files necessary to install",
      "the installation program appears to be damaged or corrupted",
      "setup was unable to shutdown system",
      "corrupt cabinet file",
      "the installer you are trying to use is corrupted",
      "hotfix package"
    };
    string short_words[mpsm_pkg::NUM_SHORT_PATTERNS] = '{
      "install", "setup", "hotfix package", "self-extractor"
    };
    bit [mpsm_pkg::SYM_W-1:0]   window[WINDOW_DEPTH];
    bit [mpsm_pkg::NUM_PAT-1:0] hit_bits;
    logic                       table_sel = mpsm_pkg::PAT_SET_SHORT;
    verdict_t                   verdicts[$];
    int unsigned                failures;

    function bit ends_with(string p);
      for (int k = 0; k < p.len(); k++) begin
        if (window[p.len() - 1 - k] != p[k]) return 1'b0;
      end
      return p.len() != 0;
    endfunction

    function void absorb_char(code_t code, logic last);
      bit [mpsm_pkg::SYM_W-1:0] sym;
      verdict_t                 v;
      if (code > 16'd127) begin
        sym = mpsm_pkg::NEVER_SYM;
      end else if (code >= "A" && code <= "Z") begin
        sym = code[mpsm_pkg::SYM_W-1:0] + 8'h20;
      end else begin
        sym = code[mpsm_pkg::SYM_W-1:0];
      end
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = sym;
      if (table_sel == mpsm_pkg::PAT_SET_LONG) begin
        for (int i = 0; i < mpsm_pkg::NUM_LONG_PATTERNS; i++) begin
          if (ends_with(long_msgs[i])) hit_bits[i] = 1'b1;
        end
      end else begin
        for (int i = 0; i < mpsm_pkg::NUM_SHORT_PATTERNS; i++) begin
          if (ends_with(short_words[i])) hit_bits[i] = 1'b1;
        end
      end
      if (last) begin
        v.found = (hit_bits != '0);
        v.index = '0;
        for (int i = mpsm_pkg::NUM_PAT - 1; i >= 0; i--) begin
          if (hit_bits[i]) v.index = mpsm_pkg::idx_t'(i);
        end
        verdicts.push_back(v);
        window = '{default: '0};
        hit_bits = '0;
      end
    endfunction

    function void check_verdict(logic found, mpsm_pkg::idx_t index);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $error("unexpected result: found %0d pattern_index %0d", found, index);
        failures++;
        return;
      end
      want = verdicts.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        failures++;
      end
      if (index !== want.index) begin
        $error("pattern_index: expected %0d, actual %0d", want.index, index);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  bit   steady;
  int unsigned items_sent;
  int unsigned strings_sent;
  match_scoreboard sb;

  code_t border_codes[10] = '{
    16'h0040, 16'h0041, 16'h005A, 16'h005B, 16'h0060,
    16'h0061, 16'h007A, 16'h007B, 16'h007F, 16'h0080
  };

  mpsm_in_if  in_ch ();
  mpsm_out_if out_ch ();

  multi_pattern_substring_matcher dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_char(input code_t code, input logic last);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.absorb_char(code, last);
    items_sent++;
  endtask

  task automatic send_text(input code_t text[$], input int unsigned from,
                           input int unsigned upto);
    for (int unsigned k = from; k < upto; k++) send_char(text[k], k == text.size() - 1);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_table(input logic sel);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.table_sel = sel;
  endtask

  function automatic code_t noise_code();
    case ($urandom_range(0, 7))
      0: return code_t'($urandom());
      1: return '0;
      2: return code_t'($urandom_range(65, 90));
      3: return code_t'($urandom_range(97, 122));
      4: return code_t'($urandom_range(0, 127));
      5: return code_t'($urandom_range(128, 255));
      6: return border_codes[$urandom_range(0, 9)];
      default: return {8'($urandom_range(1, 255)), 8'($urandom_range(97, 122))};
    endcase
  endfunction

  // random case per letter, optional single-character corruption
  function automatic void append_pattern(ref code_t text[$], input string p,
                                         input damage_t damage);
    int unsigned spot;
    code_t       code;
    spot = $urandom_range(0, p.len() - 1);
    for (int k = 0; k < p.len(); k++) begin
      code = {8'h00, p[k]};
      if (p[k] >= "a" && p[k] <= "z" && $urandom_range(0, 1) == 1) code = code - 16'h20;
      if (k == spot && damage == FLIP_BIT) code = code ^ 16'h0001;
      if (k == spot && damage == HIGH_BYTE) code[15:8] = 8'($urandom_range(1, 255));
      if (!(k == spot && damage == DROP_CHAR)) text.push_back(code);
    end
  endfunction

  function automatic string pick_pattern();
    logic from_long;
    from_long = sb.table_sel;
    if ($urandom_range(0, 7) == 0) from_long = !from_long;
    if (from_long == mpsm_pkg::PAT_SET_LONG) begin
      return sb.long_msgs[$urandom_range(0, mpsm_pkg::NUM_LONG_PATTERNS - 1)];
    end
    return sb.short_words[$urandom_range(0, mpsm_pkg::NUM_SHORT_PATTERNS - 1)];
  endfunction

  initial begin : verdict_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 18);
      @(negedge clk);
      out_ch.ready <= (stall == 0);
      if (stall != 0) begin
        do @(posedge clk); while (!out_ch.valid);
        repeat (stall - 1) @(posedge clk);
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (!out_ch.valid);
      sb.check_verdict(out_ch.found, out_ch.pattern_index);
    end
  end

  initial begin : string_source
    code_t       text[$];
    int unsigned kind;
    int unsigned cut;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = mpsm_pkg::PAT_SET_SHORT;
    rst_n           = 1'b0;
    steady          = 1'b0;
    sb = new;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lone extremes of the character code
    send_char(16'h0000, 1'b1);
    send_char(16'hFFFF, 1'b1);
    text.delete();
    append_pattern(text, "setup", INTACT);
    send_text(text, 0, text.size());
    text.delete();
    append_pattern(text, "install", INTACT);
    send_text(text, 0, text.size());
    // hit under short table survives a switch to the long table
    text.delete();
    append_pattern(text, "setup", INTACT);
    text.push_back(16'h007F);
    send_text(text, 0, text.size() - 1);
    write_table(mpsm_pkg::PAT_SET_LONG);
    send_text(text, text.size() - 1, text.size());

    while (items_sent < 950 || strings_sent < 40) begin
      steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 6) == 0) write_table(logic'($urandom_range(0, 1)));
      text.delete();
      repeat ($urandom_range(0, 5)) text.push_back(noise_code());
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        repeat ($urandom_range(1, 2)) begin
          append_pattern(text, pick_pattern(), INTACT);
          repeat ($urandom_range(0, 3)) text.push_back(noise_code());
        end
      end else if (kind < 8) begin
        append_pattern(text, pick_pattern(), damage_t'($urandom_range(1, 3)));
      end else begin
        repeat ($urandom_range(1, (kind == 9 && $urandom_range(0, 2) == 0) ? 100 : 12))
          text.push_back(noise_code());
      end
      repeat ($urandom_range(0, 4)) text.push_back(noise_code());
      if (text.size() == 0) text.push_back(noise_code());
      if ($urandom_range(0, 11) == 0 && text.size() > 1) begin
        cut = $urandom_range(1, text.size() - 1);
        send_text(text, 0, cut);
        write_table(!sb.table_sel);
        send_text(text, cut, text.size());
      end else begin
        send_text(text, 0, text.size());
      end
      strings_sent++;
    end

    steady = 1'b0;
    wait_for_results();
    repeat (5) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
